### sv/nrtp_pkg.sv
// Shared constants and types of the nested region time profiler.
`default_nettype none

package nrtp_pkg;

    // Sizes of the region table, the open-region stack and the tick counter.
    localparam int REGION_COUNT = 64;
    localparam int STACK_DEPTH  = 16;
    localparam int TIME_BITS    = 48;

    // Fixed widths of the request and result fields.
    localparam int ID_W    = 7;
    localparam int TS_W    = 48;
    localparam int NB_W    = 32;
    localparam int HIT_W   = 32;
    localparam int ACC_W   = 48;
    localparam int DEPTH_W = 5;

    // Derived widths: table address, stack level and stack index.
    localparam int RW  = $clog2(REGION_COUNT);
    localparam int SLW = $clog2(STACK_DEPTH + 1);
    localparam int SIW = $clog2(STACK_DEPTH);

    // Request kinds.
    typedef enum logic [1:0] {
        FN_BEGIN = 2'd0,
        FN_END   = 2'd1,
        FN_ADD   = 2'd2,
        FN_READ  = 2'd3
    } t_func;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BAD_ID = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // One region table entry.
    typedef struct packed {
        logic [HIT_W-1:0]     hits;
        logic [ACC_W-1:0]     excl;
        logic [ACC_W-1:0]     incl;
        logic [ACC_W-1:0]     bytes;
        logic [TIME_BITS-1:0] resume;
    } t_entry;

    // Access to the region table: one read and one write per cycle.
    typedef struct packed {
        logic          rd_en;
        logic [RW-1:0] rd_addr;
        logic          wr_en;
        logic [RW-1:0] wr_addr;
        t_entry        wr_data;
    } t_tbl_req;

    // Push or pop on the open-region stack.
    typedef struct packed {
        logic                 push;
        logic                 pop;
        logic [RW-1:0]        id;
        logic [TIME_BITS-1:0] ts;
    } t_stack_cmd;

    // What the stack shows of its upper entries.
    typedef struct packed {
        logic [SLW-1:0]       level;
        logic [RW-1:0]        top_id;
        logic [RW-1:0]        below_id;
        logic [TIME_BITS-1:0] top_begin;
    } t_stack_view;

endpackage

`default_nettype wire

### sv/nrtp_table.sv
// Region table: synchronous memory of per-region totals with reset valid bits.
`default_nettype none

module nrtp_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nrtp_pkg::t_tbl_req i_req,
    output nrtp_pkg::t_entry   o_rd_data
);

    nrtp_pkg::t_entry                      mem [nrtp_pkg::REGION_COUNT];
    logic [nrtp_pkg::REGION_COUNT-1:0]     r_valid;
    nrtp_pkg::t_entry                      r_q;
    logic                                  r_q_vld;

    // Entry storage: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_q <= mem[i_req.rd_addr];
        end
    end

    // Valid bits: an entry never written reads as all zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_q_vld <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_q_vld ? r_q : '0;

endmodule

`default_nettype wire

### sv/nrtp_stack.sv
// Open-region stack: region ids and begin ticks of the currently open visits.
`default_nettype none

module nrtp_stack (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  nrtp_pkg::t_stack_cmd  i_cmd,
    output nrtp_pkg::t_stack_view o_view
);

    logic [nrtp_pkg::RW-1:0]        r_ids    [nrtp_pkg::STACK_DEPTH];
    logic [nrtp_pkg::TIME_BITS-1:0] r_begins [nrtp_pkg::STACK_DEPTH];
    logic [nrtp_pkg::SLW-1:0]       r_level;
    logic [nrtp_pkg::RW-1:0]        r_top_id;
    logic [nrtp_pkg::SIW-1:0]       w_push_idx;
    logic [nrtp_pkg::SIW-1:0]       w_top_idx;
    logic [nrtp_pkg::SIW-1:0]       w_below_idx;

    assign w_push_idx  = nrtp_pkg::SIW'(r_level);
    assign w_top_idx   = nrtp_pkg::SIW'(r_level - nrtp_pkg::SLW'(1));
    assign w_below_idx = nrtp_pkg::SIW'(r_level - nrtp_pkg::SLW'(2));

    // Fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_cmd.push) begin
            r_level <= r_level + nrtp_pkg::SLW'(1);
        end else if (i_cmd.pop) begin
            r_level <= r_level - nrtp_pkg::SLW'(1);
        end
    end

    // Entries and a copy of the top id; the id array is read only below the top.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_ids[w_push_idx]    <= i_cmd.id;
            r_begins[w_push_idx] <= i_cmd.ts;
            r_top_id             <= i_cmd.id;
        end else if (i_cmd.pop) begin
            r_top_id <= r_ids[w_below_idx];
        end
    end

    assign o_view.level     = r_level;
    assign o_view.top_id    = r_top_id;
    assign o_view.below_id  = r_ids[w_below_idx];
    assign o_view.top_begin = r_begins[w_top_idx];

endmodule

`default_nettype wire

### sv/nested_region_time_profiler.sv
// Top level of the nested region time profiler: request decode, update sequencer, result register.
//
//  Channel  | Direction | tdata (lowest bit up)                        | tuser
//  ---------+-----------+----------------------------------------------+-------------
//  s_axis   | in        | region_id 7, timestamp 48, byte_count 32     | func 2
//  m_axis   | out       | hit_count 32, exclusive_ticks 48,            | status 2
//           |           | inclusive_ticks 48, byte_total 48, depth 5   |
//
// Each request that is not rejected makes read-modify-write passes over the region table
// memory (one read and one write port), one entry per pass: a read, an add-bytes, a begin on an
// empty stack or an end of the last open region touch one entry; a nested begin or an end that
// resumes a parent also passes over the parent's entry. A rejected request makes no pass.
// Reset is synchronous and clears the table's valid bits. A new request is taken while the
// previous result still waits on m_axis; the result stage holds until the downstream side takes it.
`default_nettype none

module nested_region_time_profiler (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [87:0]  i_s_axis_tdata,   // region_id[6:0], timestamp[54:7], byte_count[86:55]
    input  logic [1:0]   i_s_axis_tuser,   // func[1:0]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [183:0] o_m_axis_tdata,   // hit_count[31:0], exclusive_ticks[79:32],
                                           // inclusive_ticks[127:80], byte_total[175:128],
                                           // open_depth[180:176]
    output logic [1:0]   o_m_axis_tuser    // status[1:0]
);

    localparam int TW  = nrtp_pkg::TIME_BITS;
    localparam int AW  = nrtp_pkg::ACC_W;
    localparam int RW  = nrtp_pkg::RW;
    localparam int SLW = nrtp_pkg::SLW;

    // Table update applied in one pass.
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_EXCL   = 3'd1,
        OP_OPEN   = 3'd2,
        OP_CLOSE  = 3'd3,
        OP_RESUME = 3'd4,
        OP_ADD    = 3'd5
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_FIRST  = 4'b0010,
        S_SECOND = 4'b0100,
        S_OUT    = 4'b1000
    } t_state;

    typedef struct packed {
        nrtp_pkg::t_status                status;
        logic [nrtp_pkg::HIT_W-1:0]       hits;
        logic [AW-1:0]                    excl;
        logic [AW-1:0]                    incl;
        logic [AW-1:0]                    bytes;
    } t_result;

    // Apply one update to a table entry.
    function automatic nrtp_pkg::t_entry f_apply(
        input t_op                           op,
        input nrtp_pkg::t_entry              old,
        input logic [TW-1:0]                 ts,
        input logic [nrtp_pkg::NB_W-1:0]     nb,
        input logic [TW-1:0]                 begun
    );
        nrtp_pkg::t_entry e;
        logic [TW-1:0]    d_run;
        logic [TW-1:0]    d_visit;
        e       = old;
        d_run   = ts - old.resume;
        d_visit = ts - begun;
        case (op)
            OP_EXCL: begin
                e.excl = old.excl + AW'(d_run);
            end
            OP_OPEN: begin
                e.resume = ts;
                e.bytes  = old.bytes + AW'(nb);
                e.hits   = old.hits + nrtp_pkg::HIT_W'(1);
            end
            OP_CLOSE: begin
                e.excl = old.excl + AW'(d_run);
                e.incl = old.incl + AW'(d_visit);
            end
            OP_RESUME: begin
                e.resume = ts;
            end
            OP_ADD: begin
                e.bytes = old.bytes + AW'(nb);
            end
            default: begin
                e = old;
            end
        endcase
        return e;
    endfunction

    // Request fields.
    nrtp_pkg::t_func             w_func;
    logic [nrtp_pkg::ID_W-1:0]   w_id;
    logic [nrtp_pkg::TS_W-1:0]   w_ts_in;
    logic [nrtp_pkg::NB_W-1:0]   w_nb;
    logic [TW-1:0]               w_ts;

    assign w_func  = nrtp_pkg::t_func'(i_s_axis_tuser[1:0]);
    assign w_id    = i_s_axis_tdata[6:0];
    assign w_ts_in = i_s_axis_tdata[54:7];
    assign w_nb    = i_s_axis_tdata[86:55];
    assign w_ts    = TW'(w_ts_in);

    // Submodule connections.
    nrtp_pkg::t_tbl_req    tbl_req;
    nrtp_pkg::t_entry      tbl_q;
    nrtp_pkg::t_stack_cmd  stk_cmd;
    nrtp_pkg::t_stack_view stk_view;

    nrtp_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tbl_req),
        .o_rd_data (tbl_q)
    );

    nrtp_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stk_cmd),
        .o_view  (stk_view)
    );

    // Sequencer and per-request registers.
    t_state                       r_state;
    t_op                          r_op1;
    t_op                          r_op2;
    logic                         r_two;
    logic                         r_res_first;
    logic [RW-1:0]                r_a1;
    logic [RW-1:0]                r_a2;
    logic [TW-1:0]                r_ts;
    logic [nrtp_pkg::NB_W-1:0]    r_nb;
    logic [TW-1:0]                r_begun;
    nrtp_pkg::t_entry             r_ent1;
    t_result                      r_res;
    logic                         r_out_valid;
    t_result                      r_out;
    logic [nrtp_pkg::DEPTH_W-1:0] r_out_depth;

    // Request decode against the current stack.
    logic                 w_acc;
    logic                 w_id_ok;
    logic                 w_empty;
    logic                 w_full;
    logic                 w_err;
    nrtp_pkg::t_status    w_status;
    t_op                  w_op1;
    t_op                  w_op2;
    logic                 w_two;
    logic [RW-1:0]        w_a1;
    logic [RW-1:0]        w_a2;
    logic                 w_push;
    logic                 w_pop;

    assign w_acc   = i_s_axis_tvalid && (r_state == S_IDLE);
    assign w_id_ok = 32'(w_id) < 32'(nrtp_pkg::REGION_COUNT);
    assign w_empty = (stk_view.level == '0);
    assign w_full  = (stk_view.level == SLW'(nrtp_pkg::STACK_DEPTH));
    assign w_err   = (w_status != nrtp_pkg::ST_OK);

    always_comb begin
        w_status = nrtp_pkg::ST_OK;
        w_op1    = OP_NONE;
        w_op2    = OP_NONE;
        w_two    = 1'b0;
        w_a1     = stk_view.top_id;
        w_a2     = RW'(w_id);
        w_push   = 1'b0;
        w_pop    = 1'b0;
        unique case (w_func)
            nrtp_pkg::FN_BEGIN: begin
                if (!w_id_ok) begin
                    w_status = nrtp_pkg::ST_BAD_ID;
                end else if (w_full) begin
                    w_status = nrtp_pkg::ST_FULL;
                end else begin
                    w_push = 1'b1;
                    if (!w_empty) begin
                        // Pause the parent, then open the new region.
                        w_op1 = OP_EXCL;
                        w_two = 1'b1;
                        w_op2 = OP_OPEN;
                    end else begin
                        w_op1 = OP_OPEN;
                        w_a1  = RW'(w_id);
                    end
                end
            end
            nrtp_pkg::FN_END: begin
                if (w_empty) begin
                    w_status = nrtp_pkg::ST_EMPTY;
                end else begin
                    w_pop = 1'b1;
                    w_op1 = OP_CLOSE;
                    if (stk_view.level > SLW'(1)) begin
                        // The parent resumes at this tick.
                        w_two = 1'b1;
                        w_op2 = OP_RESUME;
                        w_a2  = stk_view.below_id;
                    end
                end
            end
            nrtp_pkg::FN_ADD: begin
                if (w_empty) begin
                    w_status = nrtp_pkg::ST_EMPTY;
                end else begin
                    w_op1 = OP_ADD;
                end
            end
            nrtp_pkg::FN_READ: begin
                if (!w_id_ok) begin
                    w_status = nrtp_pkg::ST_BAD_ID;
                end else begin
                    w_a1 = RW'(w_id);
                end
            end
        endcase
    end

    // Stack moves as soon as a request is taken.
    assign stk_cmd.push = w_acc && w_push;
    assign stk_cmd.pop  = w_acc && w_pop;
    assign stk_cmd.id   = RW'(w_id);
    assign stk_cmd.ts   = w_ts;

    // Current pass: old entry (forwarded when both passes hit one entry) and its update.
    t_op              w_cur_op;
    nrtp_pkg::t_entry w_cur_old;
    nrtp_pkg::t_entry w_new;

    always_comb begin
        if (r_state == S_SECOND) begin
            w_cur_op  = r_op2;
            w_cur_old = (r_a2 == r_a1) ? r_ent1 : tbl_q;
        end else begin
            w_cur_op  = r_op1;
            w_cur_old = tbl_q;
        end
        w_new = f_apply(w_cur_op, w_cur_old, r_ts, r_nb, r_begun);
    end

    // Table reads and write-backs.
    always_comb begin
        tbl_req.rd_en   = 1'b0;
        tbl_req.rd_addr = w_a1;
        tbl_req.wr_en   = 1'b0;
        tbl_req.wr_addr = r_a1;
        tbl_req.wr_data = w_new;
        if (r_state == S_IDLE) begin
            tbl_req.rd_en = w_acc && !w_err;
        end else if (r_state == S_FIRST) begin
            tbl_req.rd_en   = r_two;
            tbl_req.rd_addr = r_a2;
            tbl_req.wr_en   = (r_op1 != OP_NONE);
        end else if (r_state == S_SECOND) begin
            tbl_req.wr_en   = (r_op2 != OP_NONE);
            tbl_req.wr_addr = r_a2;
        end
    end

    logic w_out_load;
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_state <= w_err ? S_OUT : S_FIRST;
                    end
                end
                S_FIRST: begin
                    r_state <= r_two ? S_SECOND : S_OUT;
                end
                S_SECOND: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op1       <= w_op1;
            r_op2       <= w_op2;
            r_two       <= w_two;
            r_res_first <= (w_func == nrtp_pkg::FN_END);
            r_a1        <= w_a1;
            r_a2        <= w_a2;
            r_ts        <= w_ts;
            r_nb        <= w_nb;
            r_begun     <= stk_view.top_begin;
            r_res       <= '{status: w_status, default: '0};
        end
        if (r_state == S_FIRST) begin
            r_ent1 <= w_new;
            if (!r_two) begin
                r_res <= '{status: nrtp_pkg::ST_OK, hits: w_new.hits, excl: w_new.excl,
                           incl: w_new.incl, bytes: w_new.bytes};
            end
        end
        if (r_state == S_SECOND) begin
            if (r_res_first) begin
                r_res <= '{status: nrtp_pkg::ST_OK, hits: r_ent1.hits, excl: r_ent1.excl,
                           incl: r_ent1.incl, bytes: r_ent1.bytes};
            end else begin
                r_res <= '{status: nrtp_pkg::ST_OK, hits: w_new.hits, excl: w_new.excl,
                           incl: w_new.incl, bytes: w_new.bytes};
            end
        end
        if (w_out_load) begin
            r_out       <= r_res;
            r_out_depth <= nrtp_pkg::DEPTH_W'(stk_view.level);
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_depth, r_out.bytes, r_out.incl, r_out.excl,
                              r_out.hits};
    assign o_m_axis_tuser  = r_out.status;

    // Table writes happen only in the update passes.
    a_write_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_req.wr_en |-> (r_state == S_FIRST || r_state == S_SECOND))
        else $error("region table written outside an update pass");

    // The stack never holds more than its depth.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_view.level <= SLW'(nrtp_pkg::STACK_DEPTH))
        else $error("stack level beyond its depth");

    // A rejected request leaves the stack as it was.
    a_err_keeps_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_err) |=> (stk_view.level == $past(stk_view.level)))
        else $error("rejected request changed the stack");

    // An accepted begin raises the level by exactly one.
    a_push_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_push) |=> (stk_view.level == $past(stk_view.level) + SLW'(1)))
        else $error("begin did not raise the stack level by one");

endmodule

`default_nettype wire

### dv/nested_region_time_profiler_compare.sv
// Result predictor and comparator for the nested region time profiler test bench.
`default_nettype none

module nested_region_time_profiler_compare (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [87:0]  i_s_tdata,    // region_id[6:0], timestamp[54:7], byte_count[86:55]
    input  logic [1:0]   i_s_tuser,    // func[1:0]
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [183:0] i_m_tdata,    // hit_count[31:0], exclusive_ticks[79:32],
                                       // inclusive_ticks[127:80], byte_total[175:128],
                                       // open_depth[180:176]
    input  logic [1:0]   i_m_tuser,    // status[1:0]
    output int           o_fail_count,
    output int           o_pending,
    output int           o_result_count
);

    // Totals that one request is expected to return.
    typedef struct packed {
        nrtp_pkg::t_status                  status;
        logic [nrtp_pkg::HIT_W-1:0]         hits;
        logic [nrtp_pkg::ACC_W-1:0]         excl;
        logic [nrtp_pkg::ACC_W-1:0]         incl;
        logic [nrtp_pkg::ACC_W-1:0]         bytes;
        logic [nrtp_pkg::DEPTH_W-1:0]       depth;
    } t_region_totals;

    // Shadow copy of the per-region accumulators and the open-region stack.
    logic [nrtp_pkg::HIT_W-1:0]     hits_tab   [nrtp_pkg::REGION_COUNT];
    logic [nrtp_pkg::ACC_W-1:0]     excl_tab   [nrtp_pkg::REGION_COUNT];
    logic [nrtp_pkg::ACC_W-1:0]     incl_tab   [nrtp_pkg::REGION_COUNT];
    logic [nrtp_pkg::ACC_W-1:0]     bytes_tab  [nrtp_pkg::REGION_COUNT];
    logic [nrtp_pkg::TIME_BITS-1:0] resume_tab [nrtp_pkg::REGION_COUNT];
    logic [nrtp_pkg::RW-1:0]        open_ids   [nrtp_pkg::STACK_DEPTH];
    logic [nrtp_pkg::TIME_BITS-1:0] open_starts[nrtp_pkg::STACK_DEPTH];
    int                             open_level;

    t_region_totals awaited_totals[$];
    t_region_totals want;
    int             fail_total = 0;
    int             result_total = 0;

    assign o_fail_count   = fail_total;
    assign o_pending      = awaited_totals.size();
    assign o_result_count = result_total;

    // Current totals of one region, tagged with a status.
    function automatic t_region_totals totals_of(logic [nrtp_pkg::RW-1:0] r);
        t_region_totals t;
        t        = '0;
        t.status = nrtp_pkg::ST_OK;
        t.hits   = hits_tab[r];
        t.excl   = excl_tab[r];
        t.incl   = incl_tab[r];
        t.bytes  = bytes_tab[r];
        return t;
    endfunction

    // Apply one request to the shadow state and return the totals it should report.
    function automatic t_region_totals apply_request(nrtp_pkg::t_func f,
                                                     logic [nrtp_pkg::ID_W-1:0] id,
                                                     logic [nrtp_pkg::TIME_BITS-1:0] ts,
                                                     logic [nrtp_pkg::NB_W-1:0] nb);
        t_region_totals          res;
        logic [nrtp_pkg::RW-1:0] r;
        logic [nrtp_pkg::RW-1:0] p;
        res = '0;
        case (f)
            nrtp_pkg::FN_BEGIN: begin
                // The id check takes priority over the full-stack check.
                if (id >= nrtp_pkg::REGION_COUNT) begin
                    res.status = nrtp_pkg::ST_BAD_ID;
                end else if (open_level >= nrtp_pkg::STACK_DEPTH) begin
                    res.status = nrtp_pkg::ST_FULL;
                end else begin
                    r = id[nrtp_pkg::RW-1:0];
                    // The parent stops accumulating exclusive time while the child runs.
                    if (open_level > 0) begin
                        p = open_ids[open_level-1];
                        excl_tab[p] = excl_tab[p] + (ts - resume_tab[p]);
                    end
                    resume_tab[r]           = ts;
                    bytes_tab[r]            = bytes_tab[r] + nrtp_pkg::ACC_W'(nb);
                    hits_tab[r]             = hits_tab[r] + 1'b1;
                    open_ids[open_level]    = r;
                    open_starts[open_level] = ts;
                    open_level++;
                    res = totals_of(r);
                end
            end
            nrtp_pkg::FN_END: begin
                if (open_level == 0) begin
                    res.status = nrtp_pkg::ST_EMPTY;
                end else begin
                    open_level--;
                    r = open_ids[open_level];
                    excl_tab[r] = excl_tab[r] + (ts - resume_tab[r]);
                    incl_tab[r] = incl_tab[r] + (ts - open_starts[open_level]);
                    // The parent resumes its exclusive time here.
                    if (open_level > 0) begin
                        resume_tab[open_ids[open_level-1]] = ts;
                    end
                    res = totals_of(r);
                end
            end
            nrtp_pkg::FN_ADD: begin
                if (open_level == 0) begin
                    res.status = nrtp_pkg::ST_EMPTY;
                end else begin
                    r = open_ids[open_level-1];
                    bytes_tab[r] = bytes_tab[r] + nrtp_pkg::ACC_W'(nb);
                    res = totals_of(r);
                end
            end
            default: begin
                if (id >= nrtp_pkg::REGION_COUNT) begin
                    res.status = nrtp_pkg::ST_BAD_ID;
                end else begin
                    res = totals_of(id[nrtp_pkg::RW-1:0]);
                end
            end
        endcase
        res.depth = nrtp_pkg::DEPTH_W'(open_level);
        return res;
    endfunction

    // Compare one result field; every miss is counted and printed.
    task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] got_val);
        if (exp_val !== got_val) begin
            fail_total++;
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, name, exp_val, got_val);
        end
    endtask

    // Watch both channels at the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < nrtp_pkg::REGION_COUNT; i++) begin
                hits_tab[i]   = '0;
                excl_tab[i]   = '0;
                incl_tab[i]   = '0;
                bytes_tab[i]  = '0;
                resume_tab[i] = '0;
            end
            for (int i = 0; i < nrtp_pkg::STACK_DEPTH; i++) begin
                open_ids[i]    = '0;
                open_starts[i] = '0;
            end
            open_level = 0;
            awaited_totals.delete();
        end else begin
            // A result leaving the block is matched against the oldest request.
            if (i_m_tvalid && i_m_tready) begin
                result_total++;
                if (awaited_totals.size() == 0) begin
                    fail_total++;
                    $display("%0t: result with no request waiting: status %0h, data %0h",
                             $time, i_m_tuser, i_m_tdata);
                end else begin
                    want = awaited_totals.pop_front();
                    check_field("status", 64'(want.status), 64'(i_m_tuser));
                    check_field("hit_count", 64'(want.hits), 64'(i_m_tdata[31:0]));
                    check_field("exclusive_ticks", 64'(want.excl), 64'(i_m_tdata[79:32]));
                    check_field("inclusive_ticks", 64'(want.incl), 64'(i_m_tdata[127:80]));
                    check_field("byte_total", 64'(want.bytes), 64'(i_m_tdata[175:128]));
                    check_field("open_depth", 64'(want.depth), 64'(i_m_tdata[180:176]));
                end
            end
            // A request entering the block updates the shadow state.
            if (i_s_tvalid && i_s_tready) begin
                awaited_totals.push_back(apply_request(nrtp_pkg::t_func'(i_s_tuser),
                                                       i_s_tdata[6:0], i_s_tdata[54:7],
                                                       i_s_tdata[86:55]));
            end
        end
    end

endmodule

`default_nettype wire

### dv/nested_region_time_profiler_test.sv
// Top of the nested region time profiler test bench: clock, reset, requests and verdict.
`default_nettype none

module nested_region_time_profiler_test;

    localparam int RANDOM_REQUESTS = 700;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int DRAIN_CYCLES    = 16;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_valid  = 1'b0;
    logic         s_ready;
    logic [87:0]  s_data   = '0;    // region_id[6:0], timestamp[54:7], byte_count[86:55]
    logic [1:0]   s_user   = nrtp_pkg::FN_READ; // func[1:0]
    logic         m_valid;
    logic         m_ready  = 1'b0;
    logic [183:0] m_data;           // hit_count, exclusive, inclusive, byte_total, depth
    logic [1:0]   m_user;           // status[1:0]

    int fail_count;
    int pending;
    int result_count;

    // Stimulus bookkeeping: the open depth is tracked only to shape the sequences.
    logic [nrtp_pkg::TIME_BITS-1:0] tick = '0;
    bit  quiet        = 1'b0;
    int  open_depth   = 0;
    int  deepest      = 0;
    int  total_sent   = 0;
    int  kind_sent[4] = '{0, 0, 0, 0};
    int  directed_sent;
    int  ready_hold   = 0;
    int  cycles       = 0;

    nested_region_time_profiler DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    nested_region_time_profiler_compare totals_compare (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_valid),
        .i_s_tready     (s_ready),
        .i_s_tdata      (s_data),
        .i_s_tuser      (s_user),
        .i_m_tvalid     (m_valid),
        .i_m_tready     (m_ready),
        .i_m_tdata      (m_data),
        .i_m_tuser      (m_user),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // Free-running clock.
    initial begin
        forever #4 clk = ~clk;
    end

    // Runaway guard.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, pending);
            $display("nested_region_time_profiler_test: FAIL");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long, none in quiet stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Downstream stalls: ready runs alternate with stall stretches.
    always @(negedge clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (quiet || !m_ready) begin
            m_ready    <= 1'b1;
            ready_hold = $urandom_range(0, 12);
        end else begin
            m_ready    <= 1'b0;
            ready_hold = pick_gap();
        end
    end

    // Event times: mostly small steps, sometimes large ones, rarely a jump anywhere.
    function automatic logic [nrtp_pkg::TIME_BITS-1:0] next_tick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            tick = tick + nrtp_pkg::TIME_BITS'($urandom_range(0, 40));
        end else if (r < 97) begin
            tick = tick + nrtp_pkg::TIME_BITS'($urandom_range(0, 1 << 20));
        end else begin
            tick = nrtp_pkg::TIME_BITS'({$urandom, $urandom});
        end
        return tick;
    endfunction

    function automatic logic [nrtp_pkg::NB_W-1:0] rand_bytes();
        if ($urandom_range(0, 3) == 0) begin
            return nrtp_pkg::NB_W'($urandom_range(0, 255));
        end
        return nrtp_pkg::NB_W'($urandom);
    endfunction

    // Valid ids, biased toward a few regions so recursion and reuse are common.
    function automatic logic [nrtp_pkg::ID_W-1:0] pick_id();
        if ($urandom_range(0, 1) == 1) begin
            return nrtp_pkg::ID_W'($urandom_range(0, 7));
        end
        return nrtp_pkg::ID_W'($urandom_range(0, nrtp_pkg::REGION_COUNT - 1));
    endfunction

    function automatic logic [nrtp_pkg::ID_W-1:0] bad_id();
        return nrtp_pkg::ID_W'($urandom_range(nrtp_pkg::REGION_COUNT,
                                              (1 << nrtp_pkg::ID_W) - 1));
    endfunction

    function automatic logic [nrtp_pkg::ID_W-1:0] any_id();
        return nrtp_pkg::ID_W'($urandom);
    endfunction

    // Send one request: optional idle gap, then hold it until the block takes it.
    task automatic send_req(nrtp_pkg::t_func f, logic [nrtp_pkg::ID_W-1:0] id,
                            logic [nrtp_pkg::TIME_BITS-1:0] ts,
                            logic [nrtp_pkg::NB_W-1:0] nb);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {1'b0, nb, ts, id};
        s_user  <= f;
        do @(posedge clk); while (!s_ready);
        @(negedge clk);
        total_sent++;
        kind_sent[f]++;
        if (f == nrtp_pkg::FN_BEGIN && id < nrtp_pkg::REGION_COUNT &&
            open_depth < nrtp_pkg::STACK_DEPTH) begin
            open_depth++;
        end else if (f == nrtp_pkg::FN_END && open_depth > 0) begin
            open_depth--;
        end
        if (open_depth > deepest) begin
            deepest = open_depth;
        end
    endtask

    // Well-formed nesting with random content, unwound at the end.
    task automatic run_nest();
        int target;
        int steps;
        int pick;
        target = ($urandom_range(0, 4) == 0) ? $urandom_range(5, nrtp_pkg::STACK_DEPTH)
                                             : $urandom_range(1, 4);
        steps  = $urandom_range(4, 30);
        repeat (steps) begin
            pick = $urandom_range(0, 99);
            if (pick < 40 && open_depth < target) begin
                send_req(nrtp_pkg::FN_BEGIN, pick_id(), next_tick(), rand_bytes());
            end else if (pick < 70 && open_depth > 0) begin
                send_req(nrtp_pkg::FN_END, any_id(), next_tick(), rand_bytes());
            end else if (pick < 85) begin
                send_req(nrtp_pkg::FN_ADD, any_id(), next_tick(), rand_bytes());
            end else if (pick < 95) begin
                send_req(nrtp_pkg::FN_READ, pick_id(), next_tick(), rand_bytes());
            end else begin
                send_req($urandom_range(0, 1) ? nrtp_pkg::FN_BEGIN : nrtp_pkg::FN_READ,
                         bad_id(), next_tick(), rand_bytes());
            end
        end
        while (open_depth > 0) begin
            send_req(nrtp_pkg::FN_END, any_id(), next_tick(), rand_bytes());
        end
    endtask

    // Fill the stack, push past it, then unwind.
    task automatic run_deep();
        while (open_depth < nrtp_pkg::STACK_DEPTH) begin
            send_req(nrtp_pkg::FN_BEGIN, pick_id(), next_tick(), rand_bytes());
        end
        send_req(nrtp_pkg::FN_BEGIN, pick_id(), next_tick(), rand_bytes());
        send_req(nrtp_pkg::FN_BEGIN, bad_id(), next_tick(), rand_bytes());
        send_req(nrtp_pkg::FN_ADD, any_id(), next_tick(), rand_bytes());
        send_req(nrtp_pkg::FN_READ, pick_id(), next_tick(), rand_bytes());
        while (open_depth > 0) begin
            if ($urandom_range(0, 5) == 0) begin
                send_req(nrtp_pkg::FN_READ, pick_id(), next_tick(), rand_bytes());
            end
            send_req(nrtp_pkg::FN_END, any_id(), next_tick(), rand_bytes());
        end
    endtask

    // Arbitrary requests with arbitrary times, including misplaced ends and adds.
    task automatic run_noise();
        repeat ($urandom_range(3, 12)) begin
            send_req(nrtp_pkg::t_func'($urandom_range(0, 3)), any_id(),
                     nrtp_pkg::TIME_BITS'({$urandom, $urandom}), nrtp_pkg::NB_W'($urandom));
        end
    endtask

    // Main sequence.
    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty-stack and bad-id errors, wrap of times, recursion.
        send_req(nrtp_pkg::FN_READ, '0, '0, '0);
        send_req(nrtp_pkg::FN_END, '0, '1, '1);
        send_req(nrtp_pkg::FN_ADD, '1, '1, '1);
        send_req(nrtp_pkg::FN_BEGIN, nrtp_pkg::ID_W'(nrtp_pkg::REGION_COUNT), 48'h1234, '1);
        send_req(nrtp_pkg::FN_READ, '1, 48'h1235, '0);
        send_req(nrtp_pkg::FN_BEGIN, nrtp_pkg::ID_W'(nrtp_pkg::REGION_COUNT - 1),
                 48'hFFFF_FFFF_FFF0, '1);
        send_req(nrtp_pkg::FN_ADD, '0, 48'hFFFF_FFFF_FFF8, '1);
        send_req(nrtp_pkg::FN_BEGIN, '0, 48'h8, 32'h10);
        send_req(nrtp_pkg::FN_BEGIN, nrtp_pkg::ID_W'(nrtp_pkg::REGION_COUNT - 1), 48'h20,
                 32'h1);
        send_req(nrtp_pkg::FN_READ, nrtp_pkg::ID_W'(nrtp_pkg::REGION_COUNT - 1), 48'h21, '0);
        send_req(nrtp_pkg::FN_END, '0, 48'h40, '0);
        send_req(nrtp_pkg::FN_END, '0, 48'h55, '0);
        send_req(nrtp_pkg::FN_END, '0, 48'h60, '0);
        send_req(nrtp_pkg::FN_READ, nrtp_pkg::ID_W'(nrtp_pkg::REGION_COUNT - 1), 48'h61, '0);
        send_req(nrtp_pkg::FN_READ, '0, 48'h62, '0);
        send_req(nrtp_pkg::FN_BEGIN, nrtp_pkg::ID_W'(5), '1, '0);
        send_req(nrtp_pkg::FN_END, '1, '0, '1);
        directed_sent = total_sent;
        tick = 48'h100;

        // Random part: mostly well-formed nesting, one full-stack pass up front.
        run_deep();
        while (total_sent - directed_sent < RANDOM_REQUESTS) begin
            if ($urandom_range(0, 4) == 0) begin
                quiet = ~quiet;
            end
            case ($urandom_range(0, 99)) inside
                [0:74]:  run_nest();
                [75:82]: run_deep();
                default: run_noise();
            endcase
        end
        s_valid <= 1'b0;

        // Drain: every result in, then a last idle wait for anything stray.
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d requests (%0d begin, %0d end, %0d add-bytes, %0d read),",
                 total_sent, kind_sent[nrtp_pkg::FN_BEGIN], kind_sent[nrtp_pkg::FN_END],
                 kind_sent[nrtp_pkg::FN_ADD], kind_sent[nrtp_pkg::FN_READ]);
        $display("%0d results; open stack reached %0d of %0d entries; %0d failures.",
                 result_count, deepest, nrtp_pkg::STACK_DEPTH, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("nested_region_time_profiler_test: PASS");
        end else begin
            $display("nested_region_time_profiler_test: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
sv/nrtp_pkg.sv
sv/nrtp_table.sv
sv/nrtp_stack.sv
sv/nested_region_time_profiler.sv
dv/nested_region_time_profiler_compare.sv
dv/nested_region_time_profiler_test.sv
